// ===== src/dbd_pkg.sv =====
`default_nettype none
package dbd_pkg;

    localparam int BINS      = 16;
    localparam int SIDES     = 4;
    localparam int SCORE_IDX = SIDES * BINS;
    localparam int BIN_W     = $clog2(BINS);
    localparam int EI_W      = 7;
    localparam int LOG2E_Q16 = 94548;

    localparam int ES_W   = 32;
    localparam int WS_W   = 36;
    localparam int U_W    = 21;
    localparam int E_W    = 29;
    localparam int DIST_W = 20;
    localparam int NUM_W  = 50;
    localparam int DEN_W  = 32;
    localparam int QUO_W  = 24;
    localparam int K_W    = 5;

    localparam logic [K_W-1:0] K_DIST  = K_W'(20);
    localparam logic [K_W-1:0] K_CTR   = K_W'(24);
    localparam logic [K_W-1:0] K_SIZE  = K_W'(22);
    localparam logic [K_W-1:0] K_SCORE = K_W'(18);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic [17:0] POW2_TAB [17] = '{
        18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
        18'd84990,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
        18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
    };

    typedef enum logic [1:0] {
        CFG_GRID0 = 2'd0,
        CFG_GRID1 = 2'd1,
        CFG_GRID2 = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_DIST0, OP_DIST1, OP_DIST2, OP_DIST3,
        OP_CX, OP_CY, OP_W, OP_H, OP_SCORE
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_RUN, S_STORE, S_DONE
    } t_bk_state;

    typedef struct packed {
        logic [SIDES-1:0][ES_W-1:0] es;
        logic [SIDES-1:0][WS_W-1:0] ws;
        logic [1:0]                 level;
        logic [7:0]                 cx;
        logic [7:0]                 cy;
        logic [E_W-1:0]             p;
        logic [E_W-1:0]             q;
    } t_anchor;

    function automatic logic [U_W-1:0] exp_arg(input logic signed [17:0] v);
        logic signed [17:0] c;
        logic [12:0]        a;
        logic [29:0]        prod;
        if (v < -18'sd4096) begin
            c = -18'sd4096;
        end else if (v > 18'sd4095) begin
            c = 18'sd4095;
        end else begin
            c = v;
        end
        a    = 13'(c + 18'sd4096);
        prod = 30'(a) * 30'(LOG2E_Q16);
        return prod[29:9];
    endfunction

    function automatic logic [E_W-1:0] exp_val(input logic [U_W-1:0] u);
        logic [4:0]  n;
        logic [4:0]  idx;
        logic [11:0] r;
        logic [17:0] t0;
        logic [17:0] t1;
        logic [24:0] d;
        logic [17:0] m;
        logic [40:0] sh;
        n   = u[20:16];
        idx = {1'b0, u[15:12]};
        r   = u[11:0];
        t0  = POW2_TAB[idx];
        t1  = POW2_TAB[idx + 5'd1];
        d   = 25'(t1 - t0) * 25'(r);
        m   = t0 + 18'(d >> 12);
        sh  = 41'(m) << n;
        return sh[40:12];
    endfunction

endpackage
`default_nettype wire

// ===== src/dbd_front.sv =====
`default_nettype none
module dbd_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             i_level,
    input  wire logic [7:0]             i_cell_x,
    input  wire logic [7:0]             i_cell_y,
    input  wire logic [6:0]             i_element_index,
    input  wire logic signed [15:0]     i_logit,
    output logic                        o_q_push,
    output dbd_pkg::t_anchor            o_q_data,
    input  wire logic                   i_q_full
);
    import dbd_pkg::*;

    logic              stall;
    logic              take;
    logic              is_bin;
    logic              is_score;
    logic signed [17:0] xe;
    logic signed [17:0] va;
    logic signed [17:0] vb;

    logic             r_s1_vld;
    logic             r_s1_score;
    logic [1:0]       r_s1_side;
    logic [BIN_W-1:0] r_s1_bin;
    logic [U_W-1:0]   r_s1_ua;
    logic [U_W-1:0]   r_s1_ub;
    logic [1:0]       r_s1_level;
    logic [7:0]       r_s1_cx;
    logic [7:0]       r_s1_cy;

    logic             r_s2_vld;
    logic             r_s2_score;
    logic [1:0]       r_s2_side;
    logic [BIN_W-1:0] r_s2_bin;
    logic [E_W-1:0]   r_s2_ea;
    logic [E_W-1:0]   r_s2_eb;
    logic [1:0]       r_s2_level;
    logic [7:0]       r_s2_cx;
    logic [7:0]       r_s2_cy;

    logic [SIDES-1:0][ES_W-1:0] r_es;
    logic [SIDES-1:0][WS_W-1:0] r_ws;
    logic [SIDES-1:0][ES_W-1:0] n_es;
    logic [SIDES-1:0][WS_W-1:0] n_ws;
    logic [ES_W:0]              es_add;
    logic [WS_W:0]              ws_add;

    assign stall    = r_s2_vld && r_s2_score && i_q_full;
    assign full     = stall;
    assign take     = push && !stall;
    assign is_bin   = 32'(i_element_index) < SCORE_IDX;
    assign is_score = 32'(i_element_index) == SCORE_IDX;
    assign xe       = 18'(i_logit);
    assign va       = is_bin ? (xe <<< 1) : xe;
    assign vb       = -xe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_es     <= '0;
            r_ws     <= '0;
        end else begin
            r_es <= n_es;
            r_ws <= n_ws;
            if (!stall) begin
                r_s1_vld <= take && (is_bin || is_score);
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_score <= is_score;
            r_s1_side  <= 2'(i_element_index / BINS);
            r_s1_bin   <= BIN_W'(i_element_index % BINS);
            r_s1_ua    <= exp_arg(va);
            r_s1_ub    <= exp_arg(vb);
            r_s1_level <= i_level;
            r_s1_cx    <= i_cell_x;
            r_s1_cy    <= i_cell_y;
            r_s2_score <= r_s1_score;
            r_s2_side  <= r_s1_side;
            r_s2_bin   <= r_s1_bin;
            r_s2_ea    <= exp_val(r_s1_ua);
            r_s2_eb    <= exp_val(r_s1_ub);
            r_s2_level <= r_s1_level;
            r_s2_cx    <= r_s1_cx;
            r_s2_cy    <= r_s1_cy;
        end
    end

    always_comb begin
        n_es   = r_es;
        n_ws   = r_ws;
        es_add = (ES_W+1)'(r_es[r_s2_side]) + (ES_W+1)'(r_s2_ea);
        ws_add = (WS_W+1)'(r_ws[r_s2_side]) + (WS_W+1)'(r_s2_ea) * (WS_W+1)'(r_s2_bin);
        if (r_s2_vld && !stall) begin
            if (r_s2_score) begin
                n_es = '0;
                n_ws = '0;
            end else begin
                n_es[r_s2_side] = es_add[ES_W] ? '1 : es_add[ES_W-1:0];
                n_ws[r_s2_side] = ws_add[WS_W] ? '1 : ws_add[WS_W-1:0];
            end
        end
    end

    assign o_q_push       = r_s2_vld && r_s2_score && !i_q_full;
    assign o_q_data.es    = r_es;
    assign o_q_data.ws    = r_ws;
    assign o_q_data.level = r_s2_level;
    assign o_q_data.cx    = r_s2_cx;
    assign o_q_data.cy    = r_s2_cy;
    assign o_q_data.p     = r_s2_ea;
    assign o_q_data.q     = r_s2_eb;

endmodule
`default_nettype wire

// ===== src/dbd_queue.sv =====
`default_nettype none
module dbd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dbd_pkg::t_anchor  i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output dbd_pkg::t_anchor       o_data,
    output logic                   o_empty
);
    import dbd_pkg::*;

    t_anchor           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== src/dbd_back.sv =====
`default_nettype none
module dbd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dbd_pkg::t_anchor  i_q_data,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    input  wire logic [7:0]        i_grid0,
    input  wire logic [7:0]        i_grid1,
    input  wire logic [7:0]        i_grid2,
    output logic                   empty,
    input  wire logic              pop,
    output logic signed [15:0]     o_center_x,
    output logic signed [15:0]     o_center_y,
    output logic signed [15:0]     o_box_width,
    output logic signed [15:0]     o_box_height,
    output logic [15:0]            o_score
);
    import dbd_pkg::*;

    t_bk_state r_state;
    t_bk_state n_state;
    t_op       r_op;
    t_anchor   r_ent;

    logic [DIST_W-1:0] r_dist [SIDES];
    logic [15:0]       r_res [5];
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [QUO_W-1:0]  r_quo;
    logic [3:0]        r_cnt;
    logic              r_neg;
    logic              r_out_vld;
    logic [15:0]       r_out [5];

    logic [7:0]        g;
    logic [1:0]        s;
    logic [22:0]       cterm_x;
    logic [22:0]       cterm_y;
    logic signed [24:0] csum_x;
    logic signed [24:0] csum_y;
    logic [23:0]       mag;
    logic [29:0]       psum;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [K_W-1:0]    k;
    logic              neg;
    logic              skip;

    logic [DEN_W:0]    t;
    logic [DEN_W-1:0]  st_rem;
    logic [NUM_W-1:0]  st_num;
    logic [QUO_W-1:0]  st_quo;
    logic [15:0]       sat;

    logic              out_load;

    always_comb begin
        case (r_ent.level)
            2'd0:    g = i_grid0;
            2'd1:    g = i_grid1;
            default: g = i_grid2;
        endcase
        if (g == 8'd0) begin
            g = 8'd1;
        end
    end

    always_comb begin
        s       = 2'(r_op);
        cterm_x = {r_ent.cx, 1'b1, 14'b0};
        cterm_y = {r_ent.cy, 1'b1, 14'b0};
        csum_x  = $signed({2'b0, cterm_x}) + $signed({5'b0, r_dist[2]})
                - $signed({5'b0, r_dist[0]});
        csum_y  = $signed({2'b0, cterm_y}) + $signed({5'b0, r_dist[3]})
                - $signed({5'b0, r_dist[1]});
        psum    = 30'(r_ent.p) + 30'(r_ent.q);
        mag     = '0;
        num     = '0;
        den     = '0;
        k       = K_DIST;
        neg     = 1'b0;
        skip    = 1'b0;
        case (r_op)
            OP_DIST0, OP_DIST1, OP_DIST2, OP_DIST3: begin
                num  = NUM_W'({r_ent.ws[s], 14'b0});
                den  = r_ent.es[s];
                skip = r_ent.es[s] == '0;
            end
            OP_CX, OP_CY: begin
                neg = (r_op == OP_CX) ? csum_x[24] : csum_y[24];
                if (r_op == OP_CX) begin
                    mag = 24'(csum_x[24] ? -csum_x : csum_x);
                end else begin
                    mag = 24'(csum_y[24] ? -csum_y : csum_y);
                end
                num = NUM_W'(mag) + NUM_W'(g);
                den = DEN_W'({g, 1'b0});
                k   = K_CTR;
            end
            OP_W, OP_H: begin
                if (r_op == OP_W) begin
                    num = NUM_W'(r_dist[0]) + NUM_W'(r_dist[2]) + NUM_W'(g >> 1);
                end else begin
                    num = NUM_W'(r_dist[1]) + NUM_W'(r_dist[3]) + NUM_W'(g >> 1);
                end
                den = DEN_W'(g);
                k   = K_SIZE;
            end
            default: begin
                num = (NUM_W'(r_ent.p) << 16) + NUM_W'(psum >> 1);
                den = DEN_W'(psum);
                k   = K_SCORE;
            end
        endcase
    end

    always_comb begin
        st_rem = r_rem;
        st_num = r_num;
        st_quo = r_quo;
        t      = '0;
        for (int j = 0; j < 2; j++) begin
            t      = {st_rem, st_num[NUM_W-1]};
            st_num = st_num << 1;
            if (t >= {1'b0, r_den}) begin
                t      = t - {1'b0, r_den};
                st_quo = {st_quo[QUO_W-2:0], 1'b1};
            end else begin
                st_quo = {st_quo[QUO_W-2:0], 1'b0};
            end
            st_rem = t[DEN_W-1:0];
        end
    end

    always_comb begin
        if (r_op == OP_SCORE) begin
            sat = (r_quo > QUO_W'(65535)) ? 16'hFFFF : r_quo[15:0];
        end else if (r_neg) begin
            sat = (r_quo > QUO_W'(32768)) ? 16'h8000 : 16'(-r_quo);
        end else begin
            sat = (r_quo > QUO_W'(32767)) ? 16'h7FFF : r_quo[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = skip ? S_STORE : S_RUN;
            end
            S_RUN: begin
                if (r_cnt == 4'd1) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                n_state = (r_op == OP_SCORE) ? S_DONE : S_LOAD;
            end
            S_DONE: begin
                if (!r_out_vld || pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
        out_load = (r_state == S_DONE) && (!r_out_vld || pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_DIST0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_op <= OP_DIST0;
            end else if (r_state == S_STORE && r_op != OP_SCORE) begin
                r_op <= t_op'(r_op + 4'd1);
            end
            if (r_state == S_LOAD) begin
                r_cnt <= 4'(k >> 1);
            end else if (r_state == S_RUN) begin
                r_cnt <= r_cnt - 4'd1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_data;
        end
        if (r_state == S_LOAD) begin
            r_den <= den;
            r_rem <= DEN_W'(num >> k);
            r_num <= num << (6'(NUM_W) - 6'(k));
            r_quo <= '0;
            r_neg <= neg;
        end else if (r_state == S_RUN) begin
            r_rem <= st_rem;
            r_num <= st_num;
            r_quo <= st_quo;
        end
        if (r_state == S_STORE) begin
            case (r_op)
                OP_DIST0, OP_DIST1, OP_DIST2, OP_DIST3: r_dist[s] <= r_quo[DIST_W-1:0];
                OP_CX:    r_res[0] <= sat;
                OP_CY:    r_res[1] <= sat;
                OP_W:     r_res[2] <= sat;
                OP_H:     r_res[3] <= sat;
                default:  r_res[4] <= sat;
            endcase
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign empty        = !r_out_vld;
    assign o_center_x   = r_out[0];
    assign o_center_y   = r_out[1];
    assign o_box_width  = r_out[2];
    assign o_box_height = r_out[3];
    assign o_score      = r_out[4];

    a_run_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_cnt != 4'd0)
        else $error("divider running with no steps left");
    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_vld)
        else $error("result word lost");
    a_last_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE && r_op == OP_SCORE) |=> r_state == S_DONE)
        else $error("sequence did not finish after score");

endmodule
`default_nettype wire

// ===== src/dfl_box_decode_top.sv =====
// Box decoder: one anchor cell closes with each score word (index 64).
// Input channel: push/full. Each word carries level, cell position, element
// index and one Q8.8 logit. Indices 0..63 are distribution bins (left, top,
// right, bottom, 16 each); index 64 is the score logit and closes the anchor.
// Indices above 64 are dropped. The front end takes one word per cycle
// while full is low and forms table exponentials in a pipeline that accumulates
// per-side sums; full rises only while the anchor queue (two entries) is full.
// Result channel: empty/pop. One result word per anchor: normalized center,
// size (Q2.14, saturating) and sigmoid score (Q0.16). A single shared
// radix-4 divider works through nine divisions per anchor, and the back
// end finishes one anchor's result word before it takes the next anchor
// from the queue.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write the grid side of each
// level (indices 0..2); write only while idle.
// Reset (synchronous, active low) clears the sums, the queue, the result
// valid flag and restores grid sides 160, 80, 40. While pop stays low the
// result word holds; the back end then waits and the queue fills.
`default_nettype none
module dfl_box_decode_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_level,
    input  wire logic [7:0]         i_cell_x,
    input  wire logic [7:0]         i_cell_y,
    input  wire logic [6:0]         i_element_index,
    input  wire logic signed [15:0] i_logit,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      o_center_x,
    output logic signed [15:0]      o_center_y,
    output logic signed [15:0]      o_box_width,
    output logic signed [15:0]      o_box_height,
    output logic [15:0]             o_score,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data
);
    import dbd_pkg::*;

    logic [7:0] r_grid0;
    logic [7:0] r_grid1;
    logic [7:0] r_grid2;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_anchor q_wdata;
    t_anchor q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid0 <= 8'd160;
            r_grid1 <= 8'd80;
            r_grid2 <= 8'd40;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID0: r_grid0 <= i_cfg_data;
                CFG_GRID1: r_grid1 <= i_cfg_data;
                CFG_GRID2: r_grid2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dbd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_level         (i_level),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_element_index (i_element_index),
        .i_logit         (i_logit),
        .o_q_push        (q_push),
        .o_q_data        (q_wdata),
        .i_q_full        (q_full)
    );

    dbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    dbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_data     (q_rdata),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_grid0      (r_grid0),
        .i_grid1      (r_grid1),
        .i_grid2      (r_grid2),
        .empty        (empty),
        .pop          (pop),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .o_score      (o_score)
    );

endmodule
`default_nettype wire

// ===== tb/dfl_box_decode_top_tb.sv =====
`default_nettype none
module dfl_box_decode_top_tb;
    import dbd_pkg::*;

    typedef struct {
        logic [1:0]         level;
        logic [7:0]         cx;
        logic [7:0]         cy;
        logic [6:0]         ei;
        logic signed [15:0] logit;
        bit                 drain;
    } t_word;

    typedef struct {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] score;
    } t_box;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_level = '0;
    logic [7:0]         i_cell_x = '0;
    logic [7:0]         i_cell_y = '0;
    logic [6:0]         i_element_index = '0;
    logic signed [15:0] i_logit = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [15:0] o_center_x;
    logic signed [15:0] o_center_y;
    logic signed [15:0] o_box_width;
    logic signed [15:0] o_box_height;
    logic [15:0]        o_score;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [7:0]         i_cfg_data = '0;

    dfl_box_decode_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_level(i_level), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_element_index(i_element_index), .i_logit(i_logit),
        .empty(empty), .pop(pop),
        .o_center_x(o_center_x), .o_center_y(o_center_y),
        .o_box_width(o_box_width), .o_box_height(o_box_height),
        .o_score(o_score),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_word             pending_words[$];
    t_box              expected_boxes[$];
    longint unsigned   grid_side[3];
    longint unsigned   exp_acc[SIDES];
    longint unsigned   wexp_acc[SIDES];
    int                mismatches = 0;
    int                boxes_seen = 0;
    int                words_made = 0;
    int                anchors_made = 0;
    bit                send_idle_en = 1'b0;
    bit                recv_idle_en = 1'b0;
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;
    bit                just_taken = 1'b0;
    int                send_gap = 0;
    int                recv_gap = 0;
    int                hold_cnt = 0;

    function automatic longint unsigned exp_fix(int v);
        longint unsigned u;
        longint unsigned m;
        longint unsigned t0;
        longint unsigned t1;
        int              n;
        int              idx;
        if (v < -4096) v = -4096;
        if (v > 4095) v = 4095;
        u   = (longint'(v + 4096) * LOG2E_Q16) >> 9;
        n   = int'(u >> 16);
        idx = int'((u & 16'hFFFF) >> 12);
        t0  = POW2_TAB[idx];
        t1  = POW2_TAB[idx + 1];
        m   = t0 + (((t1 - t0) * (u & 12'hFFF)) >> 12);
        return (m << n) >> 12;
    endfunction

    function automatic longint signed round_div(longint signed num, longint signed den);
        if (num < 0) return -((-num + den / 2) / den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic [15:0] clip16(longint signed v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic longint signed side_distance(int s);
        if (exp_acc[s] == 0) return 0;
        return longint'((wexp_acc[s] << 14) / exp_acc[s]);
    endfunction

    task automatic accumulate_word(t_word wd);
        longint unsigned e;
        longint unsigned g;
        longint signed   dl, dt, dr, db, p, q, sc;
        int              s;
        t_box            bx;
        if (wd.ei < SCORE_IDX) begin
            s = wd.ei / BINS;
            e = exp_fix(2 * int'(wd.logit));
            exp_acc[s]  += e;
            wexp_acc[s] += e * (wd.ei % BINS);
            if (exp_acc[s] > 64'hFFFF_FFFF) exp_acc[s] = 64'hFFFF_FFFF;
            if (wexp_acc[s] > 64'hF_FFFF_FFFF) wexp_acc[s] = 64'hF_FFFF_FFFF;
        end else if (wd.ei == SCORE_IDX) begin
            g = grid_side[(wd.level == 2'd3) ? 2 : wd.level];
            if (g == 0) g = 1;
            dl = side_distance(0);
            dt = side_distance(1);
            dr = side_distance(2);
            db = side_distance(3);
            bx.cx = clip16(round_div((2 * longint'(wd.cx) + 1) * 16384 + dr - dl, 2 * g));
            bx.cy = clip16(round_div((2 * longint'(wd.cy) + 1) * 16384 + db - dt, 2 * g));
            bx.w  = clip16(round_div(dl + dr, g));
            bx.h  = clip16(round_div(dt + db, g));
            p  = exp_fix(int'(wd.logit));
            q  = exp_fix(-int'(wd.logit));
            sc = (p * 65536 + (p + q) / 2) / (p + q);
            if (sc > 65535) sc = 65535;
            bx.score = sc[15:0];
            expected_boxes.push_back(bx);
            for (int i = 0; i < SIDES; i++) begin
                exp_acc[i]  = 0;
                wexp_acc[i] = 0;
            end
        end
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(15, 80);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [15:0] pick_logit();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    task automatic add_word(logic [1:0] lv, logic [7:0] x, logic [7:0] y,
                            logic [6:0] ei, logic signed [15:0] lg, bit drain = 0);
        t_word wd;
        wd.level = lv; wd.cx = x; wd.cy = y; wd.ei = ei; wd.logit = lg; wd.drain = drain;
        pending_words.push_back(wd);
        if (ei <= SCORE_IDX) words_made++;
        if (ei == SCORE_IDX) anchors_made++;
    endtask

    task automatic add_anchor(bit whole);
        logic [1:0] lv;
        logic [7:0] x;
        logic [7:0] y;
        int         k;
        lv = 2'($urandom_range(0, 3));
        x  = 8'($urandom);
        y  = 8'($urandom);
        if (whole) begin
            for (int i = 0; i < SCORE_IDX; i++) add_word(lv, x, y, 7'(i), pick_logit());
        end else begin
            k = $urandom_range(0, 6);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(0, 9) == 0)
                    add_word(lv, x, y, 7'($urandom_range(SCORE_IDX + 1, 127)), pick_logit());
                add_word(lv, x, y, 7'($urandom_range(0, SCORE_IDX - 1)), pick_logit());
            end
        end
        add_word(2'($urandom_range(0, 3)), x, y, 7'(SCORE_IDX), pick_logit());
    endtask

    task automatic write_grid(t_cfg_idx idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        grid_side[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        wait (pending_words.size() == 0 && expected_boxes.size() == 0);
        repeat (150) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
        end else if (pending_words.size() == 0 ||
                     (pending_words[0].drain && expected_boxes.size() != 0)) begin
            push <= 1'b0;
        end else if (send_idle_en && (!push || just_taken) && $urandom_range(0, 5) == 0) begin
            send_gap = pick_gap() - 1;
            push <= 1'b0;
        end else begin
            push            <= 1'b1;
            i_level         <= pending_words[0].level;
            i_cell_x        <= pending_words[0].cx;
            i_cell_y        <= pending_words[0].cy;
            i_element_index <= pending_words[0].ei;
            i_logit         <= pending_words[0].logit;
        end
    end

    always @(posedge i_clk) begin
        just_taken = i_rst_n && push && !full;
        if (just_taken) begin
            accumulate_word(pending_words.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_cnt  = 600;
            hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
        end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
            recv_gap = pick_gap() - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_box bx;
        if (i_rst_n && pop && !empty) begin
            boxes_seen++;
            if (expected_boxes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                bx = expected_boxes.pop_front();
                if (bx.cx !== o_center_x || bx.cy !== o_center_y || bx.w !== o_box_width ||
                    bx.h !== o_box_height || bx.score !== o_score) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp cx %h cy %h w %h h %h s %h / got %h %h %h %h %h",
                                 bx.cx, bx.cy, bx.w, bx.h, bx.score, o_center_x,
                                 o_center_y, o_box_width, o_box_height, o_score);
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int target;
        grid_side[0] = 160;
        grid_side[1] = 80;
        grid_side[2] = 40;
        for (int i = 0; i < SIDES; i++) begin
            exp_acc[i]  = 0;
            wexp_acc[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty anchor, extremes, every side, ignored indices, level three
        add_word(2'd0, 8'd0, 8'd0, 7'(SCORE_IDX), 16'sh0000);
        add_word(2'd1, 8'd255, 8'd255, 7'd0, 16'sh7FFF);
        add_word(2'd1, 8'd255, 8'd255, 7'd15, 16'sh8000);
        add_word(2'd1, 8'd255, 8'd255, 7'd16, 16'sh7FFF);
        add_word(2'd1, 8'd255, 8'd255, 7'd31, 16'sh0100);
        add_word(2'd1, 8'd255, 8'd255, 7'd32, 16'shFF00);
        add_word(2'd1, 8'd255, 8'd255, 7'd47, 16'sh7FFF);
        add_word(2'd1, 8'd255, 8'd255, 7'd48, 16'sh0000);
        add_word(2'd1, 8'd255, 8'd255, 7'd63, 16'sh7FFF);
        add_word(2'd1, 8'd255, 8'd255, 7'd127, 16'sh1234);
        add_word(2'd1, 8'd255, 8'd255, 7'(SCORE_IDX), 16'sh7FFF);
        add_word(2'd3, 8'd0, 8'd255, 7'd31, 16'sh7FFF);
        add_word(2'd3, 8'd0, 8'd255, 7'd63, 16'sh7FFF);
        add_word(2'd3, 8'd0, 8'd255, 7'(SCORE_IDX + 1), 16'sh0000);
        add_word(2'd3, 8'd0, 8'd255, 7'(SCORE_IDX), 16'sh8000);
        add_word(2'd2, 8'd128, 8'd7, 7'd0, 16'sh8000);
        add_word(2'd2, 8'd128, 8'd7, 7'd47, 16'sh8000);
        add_word(2'd2, 8'd128, 8'd7, 7'(SCORE_IDX), 16'shFFFF);
        settle();

        for (int phase = 1; phase <= 3; phase++) begin
            case (phase)
                1: begin
                    write_grid(CFG_GRID0, 8'd1);
                    write_grid(CFG_GRID1, 8'd255);
                    write_grid(CFG_GRID2, 8'd1);
                end
                2: begin
                    write_grid(CFG_GRID0, 8'd255);
                    write_grid(CFG_GRID1, 8'd1);
                    write_grid(CFG_GRID2, 8'd255);
                end
                default: begin
                    write_grid(CFG_GRID0, 8'($urandom_range(1, 255)));
                    write_grid(CFG_GRID1, 8'($urandom_range(1, 255)));
                    write_grid(CFG_GRID2, 8'($urandom_range(1, 255)));
                end
            endcase
            send_idle_en = (phase != 1);
            recv_idle_en = (phase != 1);
            if (phase == 1) hold_req = 1'b1;
            target = words_made + 135;
            if (phase == 2) begin
                add_anchor(1'b1);
                for (int i = 0; i < 40; i++) add_word(2'd0, 8'd3, 8'd9, 7'd15, 16'sh7FFF);
                add_word(2'd0, 8'd3, 8'd9, 7'd0, 16'sh7FFF, 1'b1);
                add_word(2'd0, 8'd3, 8'd9, 7'(SCORE_IDX), 16'sh0000);
            end
            while (words_made < target || anchors_made < 18 * phase) begin
                add_anchor($urandom_range(0, 19) == 0);
            end
            settle();
        end

        if (expected_boxes.size() != 0) mismatches++;
        $display("%0d words sent, %0d anchors, %0d boxes checked over four grid settings",
                 words_made, anchors_made, boxes_seen);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
